@@ src/triangle_tangent_from_vertex_store_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the triangle tangent block
// Shared property forms, clocked on i_clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_TANGENT_FROM_VERTEX_STORE_MACROS_SVH
`define TRIANGLE_TANGENT_FROM_VERTEX_STORE_MACROS_SVH

// same-cycle implication
`define TTFVS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TTFVS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/ttfvs_pkg.sv @@
// ----------------------------------------------------------------------------
// ttfvs_pkg
// Types and codes shared by the vertex store and the tangent math unit.
// ----------------------------------------------------------------------------
package ttfvs_pkg;

    localparam logic [1:0] ACT_ADD_VERTEX = 2'd0;
    localparam logic [1:0] ACT_ADD_TRI    = 2'd1;
    localparam logic [1:0] ACT_CLEAR      = 2'd2;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_FULL       = 3'd1;
    localparam logic [2:0] ST_BAD_INDEX  = 3'd2;
    localparam logic [2:0] ST_DEGENERATE = 3'd3;
    localparam logic [2:0] ST_DISABLED   = 3'd4;

    localparam logic [0:0] REG_TANGENT_ENABLE = 1'b0;

    localparam int CORNER_W = 10;

    // one stored vertex, pos_x in the lowest bits
    typedef struct packed {
        logic signed [31:0] tex_v;
        logic signed [31:0] tex_u;
        logic signed [31:0] pos_z;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
    } t_vertex;

    typedef struct packed {
        logic               done;
        logic [2:0]         status;
        logic signed [31:0] tangent_x;
        logic signed [31:0] tangent_y;
        logic signed [31:0] tangent_z;
    } t_calc_res;

endpackage

@@ src/ttfvs_tangent.sv @@
// ----------------------------------------------------------------------------
// ttfvs_tangent
// Sequential tangent unit: deltas, eight products on one shared multiplier,
// normalization shifter, bit-serial square root and restoring divider.
// ----------------------------------------------------------------------------
module ttfvs_tangent (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  ttfvs_pkg::t_vertex   i_va,
    input  ttfvs_pkg::t_vertex   i_vb,
    input  ttfvs_pkg::t_vertex   i_vc,
    output ttfvs_pkg::t_calc_res o_res
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DELTA = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_CHK   = 4'd3;
    localparam logic [3:0] S_NORM  = 4'd4;
    localparam logic [3:0] S_SQ    = 4'd5;
    localparam logic [3:0] S_SQRT  = 4'd6;
    localparam logic [3:0] S_DIVI  = 4'd7;
    localparam logic [3:0] S_DIVS  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0]         r_state;
    logic [3:0]         r_k;
    logic [1:0]         r_comp;
    logic [4:0]         r_dcnt;
    logic signed [32:0] r_du1, r_dv1, r_du2, r_dv2;
    logic signed [32:0] r_e1 [3];
    logic signed [32:0] r_e2 [3];
    logic signed [65:0] r_prod;
    logic signed [66:0] r_acc [4];
    logic [65:0]        r_mag [3];
    logic               r_neg [3];
    logic [63:0]        r_sum;
    logic [63:0]        r_sqv;
    logic [63:0]        r_res;
    logic [63:0]        r_bit;
    logic [31:0]        r_rem;
    logic [30:0]        r_lo;
    logic [30:0]        r_q;
    logic [2:0]         r_status;
    logic signed [31:0] r_t [3];

    logic signed [32:0] w_mul_a, w_mul_b;
    logic signed [65:0] w_prod;
    logic [65:0]        w_abs [3];
    logic [65:0]        w_or_chk;
    logic [65:0]        w_or;
    logic [63:0]        w_sum;
    logic [63:0]        w_sq_t;
    logic [61:0]        w_num;
    logic [32:0]        w_tmp;
    logic [32:0]        w_len;
    logic               w_ge;
    logic [30:0]        w_q;
    logic [2:0]         w_j;
    logic [66:0]        w_negv [3];

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_MUL: begin
                case (r_k[2:0])
                    3'd0: begin w_mul_a = r_du1; w_mul_b = r_dv2; end
                    3'd1: begin w_mul_a = r_du2; w_mul_b = r_dv1; end
                    3'd2: begin w_mul_a = r_dv2; w_mul_b = r_e1[0]; end
                    3'd3: begin w_mul_a = r_dv1; w_mul_b = r_e2[0]; end
                    3'd4: begin w_mul_a = r_dv2; w_mul_b = r_e1[1]; end
                    3'd5: begin w_mul_a = r_dv1; w_mul_b = r_e2[1]; end
                    3'd6: begin w_mul_a = r_dv2; w_mul_b = r_e1[2]; end
                    default: begin w_mul_a = r_dv1; w_mul_b = r_e2[2]; end
                endcase
            end
            S_SQ: begin
                if (r_k[1:0] != 2'd3) begin
                    w_mul_a = {2'b00, r_mag[r_k[1:0]][30:0]};
                    w_mul_b = {2'b00, r_mag[r_k[1:0]][30:0]};
                end
            end
            default: begin
                w_mul_a = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;
    assign w_j    = r_k[2:0] - 3'd1;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_negv[i] = -r_acc[i + 1];
            w_abs[i]  = r_acc[i + 1][66] ? w_negv[i][65:0] : r_acc[i + 1][65:0];
        end
    end

    assign w_or_chk = w_abs[0] | w_abs[1] | w_abs[2];
    assign w_or     = r_mag[0] | r_mag[1] | r_mag[2];
    assign w_sum    = r_sum + {2'b00, r_prod[61:0]};
    assign w_sq_t   = r_res + r_bit;
    assign w_num    = {1'b0, r_mag[r_comp][30:0], 30'b0} + {31'b0, r_res[31:1]};
    assign w_len    = {1'b0, r_res[31:0]};
    assign w_tmp    = {r_rem, r_lo[30]};
    assign w_ge     = (w_tmp >= w_len);
    assign w_q      = {r_q[29:0], w_ge};

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_DELTA;
                    end
                end
                S_DELTA: begin
                    r_du1    <= 33'(i_vb.tex_u) - 33'(i_va.tex_u);
                    r_dv1    <= 33'(i_vb.tex_v) - 33'(i_va.tex_v);
                    r_du2    <= 33'(i_vc.tex_u) - 33'(i_va.tex_u);
                    r_dv2    <= 33'(i_vc.tex_v) - 33'(i_va.tex_v);
                    r_e1[0]  <= 33'(i_vb.pos_x) - 33'(i_va.pos_x);
                    r_e1[1]  <= 33'(i_vb.pos_y) - 33'(i_va.pos_y);
                    r_e1[2]  <= 33'(i_vb.pos_z) - 33'(i_va.pos_z);
                    r_e2[0]  <= 33'(i_vc.pos_x) - 33'(i_va.pos_x);
                    r_e2[1]  <= 33'(i_vc.pos_y) - 33'(i_va.pos_y);
                    r_e2[2]  <= 33'(i_vc.pos_z) - 33'(i_va.pos_z);
                    for (int i = 0; i < 3; i++) begin
                        r_t[i] <= '0;
                    end
                    r_k      <= '0;
                    r_state  <= S_MUL;
                end
                S_MUL: begin
                    // fold the previous product: even slots load, odd slots subtract
                    if (r_k != 4'd0) begin
                        if (!w_j[0]) begin
                            r_acc[w_j[2:1]] <= {r_prod[65], r_prod};
                        end else begin
                            r_acc[w_j[2:1]] <= r_acc[w_j[2:1]] - {r_prod[65], r_prod};
                        end
                    end
                    r_k <= r_k + 4'd1;
                    if (r_k == 4'd8) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    for (int i = 0; i < 3; i++) begin
                        r_mag[i] <= w_abs[i];
                        r_neg[i] <= r_acc[i + 1][66] ^ r_acc[0][66];
                    end
                    if (r_acc[0] == '0 || w_or_chk == '0) begin
                        r_status <= ttfvs_pkg::ST_DEGENERATE;
                        r_state  <= S_DONE;
                    end else begin
                        r_state  <= S_NORM;
                    end
                end
                S_NORM: begin
                    // bring the widest magnitude to exactly 31 bits
                    if (|w_or[65:39]) begin
                        for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] >> 8;
                    end else if (|w_or[65:31]) begin
                        for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] >> 1;
                    end else if (w_or[30:23] == 8'd0) begin
                        for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] << 8;
                    end else if (!w_or[30]) begin
                        for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] << 1;
                    end else begin
                        r_k     <= '0;
                        r_sum   <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (r_k != 4'd0) begin
                        r_sum <= w_sum;
                    end
                    r_k <= r_k + 4'd1;
                    if (r_k == 4'd3) begin
                        r_sqv   <= w_sum;
                        r_res   <= '0;
                        r_bit   <= 64'd1 << 62;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_sqv >= w_sq_t) begin
                        r_sqv <= r_sqv - w_sq_t;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_comp  <= '0;
                        r_state <= S_DIVI;
                    end
                end
                S_DIVI: begin
                    r_rem   <= w_num[61:30] >> 1;
                    r_lo    <= w_num[30:0];
                    r_q     <= '0;
                    r_dcnt  <= '0;
                    r_state <= S_DIVS;
                end
                S_DIVS: begin
                    r_rem  <= w_ge ? 32'(w_tmp - w_len) : w_tmp[31:0];
                    r_lo   <= {r_lo[29:0], 1'b0};
                    r_q    <= w_q;
                    r_dcnt <= r_dcnt + 5'd1;
                    if (r_dcnt == 5'd30) begin
                        r_t[r_comp] <= r_neg[r_comp] ? -{1'b0, w_q} : {1'b0, w_q};
                        if (r_comp == 2'd2) begin
                            r_status <= ttfvs_pkg::ST_OK;
                            r_state  <= S_DONE;
                        end else begin
                            r_comp  <= r_comp + 2'd1;
                            r_state <= S_DIVI;
                        end
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.done      = (r_state == S_DONE);
    assign o_res.status    = r_status;
    assign o_res.tangent_x = r_t[0];
    assign o_res.tangent_y = r_t[1];
    assign o_res.tangent_z = r_t[2];

endmodule

@@ src/triangle_tangent_from_vertex_store.sv @@
// ----------------------------------------------------------------------------
// triangle_tangent_from_vertex_store
// Vertex store with a per-triangle unit tangent.
// Input beats on s_axis carry an action in tuser: add vertex, add triangle or
// clear. Every input beat gives exactly one output beat on m_axis (status in
// tuser). Add vertex, clear and rejected triangles skip the tangent unit.
// A triangle that computes reads its three corners from the store, then runs
// 8 products on one multiplier, up to 10 normalize steps, 32 square-root
// steps and three restoring divisions, one item at a time.
// s_axis_tready is high while the block is idle; a finished result sits in the
// output register, so the next beat is taken while m_axis is stalled, and the
// block holds at its end until that register frees up.
// Reset empties the store (count zero, contents left as they are) and sets
// tangent_enable to 1. tangent_enable sits at byte address 0 of the APB port.
// ----------------------------------------------------------------------------
`include "triangle_tangent_from_vertex_store_macros.svh"

module triangle_tangent_from_vertex_store #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v, corner_a, corner_b, corner_c, pad
    input  logic [191:0] s_axis_tdata,
    // action
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // new_index, tangent_x, tangent_y, tangent_z, pad
    output logic [111:0] m_axis_tdata,
    // status
    output logic [2:0]   m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int XW = (CW > ttfvs_pkg::CORNER_W) ? CW : ttfvs_pkg::CORNER_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_CALC = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [159:0]           r_mem [MAX_VERTICES];
    logic [159:0]           r_rd_data;
    logic [1:0]             r_state;
    logic [1:0]             r_rd_cnt;
    logic [CW-1:0]          r_count;
    logic                   r_tan_en;
    logic [AW-1:0]          r_ca, r_cb, r_cc;
    ttfvs_pkg::t_vertex     r_va, r_vb, r_vc;
    logic                   r_start;
    logic [2:0]             r_p_status;
    logic [9:0]             r_p_index;
    logic [31:0]            r_p_tx, r_p_ty, r_p_tz;
    logic                   r_m_valid;
    logic [2:0]             r_m_status;
    logic [9:0]             r_m_index;
    logic [31:0]            r_m_tx, r_m_ty, r_m_tz;

    ttfvs_pkg::t_vertex     w_in_vtx;
    ttfvs_pkg::t_calc_res   w_calc;
    logic [XW-1:0]          w_a, w_b, w_c, w_cnt;
    logic [XW-1:0]          w_cnt_ext;
    logic                   w_accept;
    logic                   w_full;
    logic                   w_bad;
    logic                   w_we;
    logic [AW-1:0]          w_rd_addr;
    logic                   w_out_free;

    assign w_in_vtx  = ttfvs_pkg::t_vertex'(s_axis_tdata[159:0]);
    assign w_a       = XW'(s_axis_tdata[169:160]);
    assign w_b       = XW'(s_axis_tdata[179:170]);
    assign w_c       = XW'(s_axis_tdata[189:180]);
    assign w_cnt     = XW'(r_count);
    assign w_cnt_ext = w_cnt;
    assign w_accept  = s_axis_tvalid && s_axis_tready;
    assign w_full    = (r_count >= CW'(MAX_VERTICES));
    assign w_bad     = (w_a >= w_cnt) || (w_b >= w_cnt) || (w_c >= w_cnt);
    assign w_we      = w_accept && (s_axis_tuser == ttfvs_pkg::ACT_ADD_VERTEX) && !w_full;
    assign w_out_free = !r_m_valid || m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        case (r_rd_cnt)
            2'd0:    w_rd_addr = r_ca;
            2'd1:    w_rd_addr = r_cb;
            default: w_rd_addr = r_cc;
        endcase
    end

    // vertex store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_count[AW-1:0]] <= w_in_vtx;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    ttfvs_tangent u_tangent (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_va    (r_va),
        .i_vb    (r_vb),
        .i_vc    (r_vc),
        .o_res   (w_calc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_cnt  <= '0;
            r_count   <= '0;
            r_tan_en  <= 1'b1;
            r_start   <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (psel && penable && pwrite && pready
                    && paddr[2] == ttfvs_pkg::REG_TANGENT_ENABLE) begin
                r_tan_en <= pwdata[0];
            end

            if (r_m_valid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_p_status <= ttfvs_pkg::ST_OK;
                        r_p_index  <= '0;
                        r_p_tx     <= '0;
                        r_p_ty     <= '0;
                        r_p_tz     <= '0;
                        r_state    <= S_OUT;
                        case (s_axis_tuser)
                            ttfvs_pkg::ACT_ADD_VERTEX: begin
                                if (w_full) begin
                                    r_p_status <= ttfvs_pkg::ST_FULL;
                                end else begin
                                    r_p_index <= w_cnt_ext[9:0];
                                    r_count   <= r_count + CW'(1);
                                end
                            end
                            ttfvs_pkg::ACT_ADD_TRI: begin
                                if (w_bad) begin
                                    r_p_status <= ttfvs_pkg::ST_BAD_INDEX;
                                end else if (!r_tan_en) begin
                                    r_p_status <= ttfvs_pkg::ST_DISABLED;
                                end else begin
                                    r_ca     <= w_a[AW-1:0];
                                    r_cb     <= w_b[AW-1:0];
                                    r_cc     <= w_c[AW-1:0];
                                    r_rd_cnt <= '0;
                                    r_state  <= S_RD;
                                end
                            end
                            ttfvs_pkg::ACT_CLEAR: begin
                                r_count <= '0;
                            end
                            default: begin
                                r_p_status <= ttfvs_pkg::ST_OK;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    // read data is registered and arrives in the cycle after its address
                    r_rd_cnt <= r_rd_cnt + 2'd1;
                    case (r_rd_cnt)
                        2'd1:    r_va <= r_rd_data;
                        2'd2:    r_vb <= r_rd_data;
                        2'd3: begin
                            r_vc    <= r_rd_data;
                            r_start <= 1'b1;
                            r_state <= S_CALC;
                        end
                        default: r_rd_cnt <= 2'd1;
                    endcase
                end
                S_CALC: begin
                    if (w_calc.done) begin
                        r_p_status <= w_calc.status;
                        r_p_tx     <= w_calc.tangent_x;
                        r_p_ty     <= w_calc.tangent_y;
                        r_p_tz     <= w_calc.tangent_z;
                        r_state    <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold until the output register can take the beat
                    if (w_out_free) begin
                        r_m_valid  <= 1'b1;
                        r_m_status <= r_p_status;
                        r_m_index  <= r_p_index;
                        r_m_tx     <= r_p_tx;
                        r_m_ty     <= r_p_ty;
                        r_m_tz     <= r_p_tz;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_status;
    assign m_axis_tdata  = {6'b0, r_m_tz, r_m_ty, r_m_tx, r_m_index};

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ttfvs_pkg::REG_TANGENT_ENABLE) ? {31'b0, r_tan_en} : 32'b0;

    `TTFVS_ASSERT_NXT(a_count_advances, w_we, r_count == $past(r_count) + CW'(1), "vertex count did not advance")
    `TTFVS_ASSERT_IMP(a_err_zero_tangent, m_axis_tvalid && m_axis_tuser != ttfvs_pkg::ST_OK, m_axis_tdata[105:10] == '0, "tangent not zero on error")
    `TTFVS_ASSERT_IMP(a_index_only_ok, m_axis_tvalid && m_axis_tdata[9:0] != '0, m_axis_tuser == ttfvs_pkg::ST_OK, "index given with error status")
    `TTFVS_ASSERT_IMP(a_calc_when_waiting, w_calc.done, r_state == S_CALC, "tangent result outside calc")

endmodule
